>>> src/rhc_pkg.sv
// rgb_hsl_converter shared package: channel widths, command codes, hue sectors
// and fixed constants of the conversion. No dependencies.
package rhc_pkg;

  localparam int CHAN_W       = 8;
  localparam int HUE_INT_W    = 9;
  localparam int SEC_W        = 3;
  localparam int HUE_SEG_DEG  = 60;
  localparam int HUE_FULL_DEG = 360;
  localparam int CHAN_MAX     = 255;
  localparam int CHAN_SUM_MAX = 510;
  localparam int HUE_NUM_W    = 17;

  typedef logic [CHAN_W-1:0] chan_t;

  typedef enum logic {
    CMD_TO_HSL = 1'b0,
    CMD_TO_RGB = 1'b1
  } cmd_t;

  typedef enum logic [SEC_W-1:0] {
    SEC_RED_YEL = 3'd0,
    SEC_YEL_GRN = 3'd1,
    SEC_GRN_CYN = 3'd2,
    SEC_CYN_BLU = 3'd3,
    SEC_BLU_MAG = 3'd4,
    SEC_MAG_RED = 3'd5
  } sector_t;

endpackage

>>> src/rhc_if.sv
// pixel channel interfaces of rgb_hsl_converter: valid/ready plus payload
// depends on rhc_pkg
interface rhc_in_if #(
  parameter int HW = 15,
  parameter int FW = 13
);
  logic           valid;
  logic           ready;
  rhc_pkg::cmd_t  command;
  rhc_pkg::chan_t in_red;
  rhc_pkg::chan_t in_green;
  rhc_pkg::chan_t in_blue;
  logic [HW-1:0]  in_hue;
  logic [FW-1:0]  in_saturation;
  logic [FW-1:0]  in_lightness;

  modport source (
    output valid, command, in_red, in_green, in_blue, in_hue, in_saturation, in_lightness,
    input  ready
  );
  modport sink (
    input  valid, command, in_red, in_green, in_blue, in_hue, in_saturation, in_lightness,
    output ready
  );
endinterface

interface rhc_out_if #(
  parameter int HW = 15,
  parameter int FW = 13
);
  logic           valid;
  logic           ready;
  rhc_pkg::chan_t out_red;
  rhc_pkg::chan_t out_green;
  rhc_pkg::chan_t out_blue;
  logic [HW-1:0]  out_hue;
  logic [FW-1:0]  out_saturation;
  logic [FW-1:0]  out_lightness;

  modport source (
    output valid, out_red, out_green, out_blue, out_hue, out_saturation, out_lightness,
    input  ready
  );
  modport sink (
    input  valid, out_red, out_green, out_blue, out_hue, out_saturation, out_lightness,
    output ready
  );
endinterface

>>> src/rhc_divider.sv
// pipelined restoring divider, one quotient bit per stage, several lanes
// sharing valid and sideband; no package dependencies
module rhc_divider #(
  parameter int LANES = 3,
  parameter int NW    = 25,
  parameter int DW    = 12,
  parameter int QW    = 15,
  parameter int SW    = 31
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          en,
  input  logic          in_valid,
  input  logic [NW-1:0] num [LANES],
  input  logic [DW-1:0] den [LANES],
  input  logic [SW-1:0] side_in,
  output logic          out_valid,
  output logic [QW-1:0] quo [LANES],
  output logic [SW-1:0] side_out
);

  logic          v_r    [QW];
  logic [SW-1:0] side_r [QW];
  logic [DW-1:0] rem_r  [QW][LANES];
  logic [QW-1:0] work_r [QW][LANES];
  logic [DW-1:0] den_r  [QW][LANES];

  for (genvar st = 0; st < QW; st++) begin : g_st
    logic          valid_in;
    logic [SW-1:0] side_in_s;
    logic [DW-1:0] rem_in   [LANES];
    logic [QW-1:0] work_in  [LANES];
    logic [DW-1:0] den_in   [LANES];
    logic [DW-1:0] rem_nxt  [LANES];
    logic [QW-1:0] work_nxt [LANES];

    if (st == 0) begin : g_first
      assign valid_in  = in_valid;
      assign side_in_s = side_in;
      always_comb begin
        for (int ln = 0; ln < LANES; ln++) begin
          rem_in[ln]  = DW'(num[ln] >> QW);
          work_in[ln] = num[ln][QW-1:0];
          den_in[ln]  = den[ln];
        end
      end
    end else begin : g_next
      assign valid_in  = v_r[st-1];
      assign side_in_s = side_r[st-1];
      always_comb begin
        for (int ln = 0; ln < LANES; ln++) begin
          rem_in[ln]  = rem_r[st-1][ln];
          work_in[ln] = work_r[st-1][ln];
          den_in[ln]  = den_r[st-1][ln];
        end
      end
    end

    always_comb begin
      logic [DW:0] trial;
      logic        ge;
      for (int ln = 0; ln < LANES; ln++) begin
        trial        = {rem_in[ln], work_in[ln][QW-1]};
        ge           = (trial >= {1'b0, den_in[ln]});
        rem_nxt[ln]  = ge ? DW'(trial - {1'b0, den_in[ln]}) : trial[DW-1:0];
        work_nxt[ln] = {work_in[ln][QW-2:0], ge};
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[st] <= 1'b0;
      end else if (en) begin
        v_r[st] <= valid_in;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        side_r[st] <= side_in_s;
        for (int ln = 0; ln < LANES; ln++) begin
          rem_r[st][ln]  <= rem_nxt[ln];
          work_r[st][ln] <= work_nxt[ln];
          den_r[st][ln]  <= den_in[ln];
        end
      end
    end
  end

  assign out_valid = v_r[QW-1];
  assign side_out  = side_r[QW-1];
  always_comb begin
    for (int ln = 0; ln < LANES; ln++) begin
      quo[ln] = work_r[QW-1][ln];
    end
  end

endmodule

>>> src/rgb_hsl_converter.sv
// rgb_hsl_converter top level: per-pixel rgb/hsl conversion pipeline
// depends on rhc_pkg, rhc_if and rhc_divider
// stages in order: stage 0, stage 1, stage 2, the divider, post stage 1, post stage 2
// throughput: one pixel per cycle; the whole pipeline freezes while the output is stalled
// the depth is set by the divider, which resolves one quotient bit per stage
// reset clears the valid bits only; payload registers are not reset
module rgb_hsl_converter #(
  parameter int FRACTION_BITS     = 12,
  parameter int HUE_FRACTION_BITS = 6
) (
  input  logic      clk,
  input  logic      rst_n,
  rhc_in_if.sink    in_ch,
  rhc_out_if.source out_ch
);

  localparam int FB    = FRACTION_BITS;
  localparam int HFB   = HUE_FRACTION_BITS;
  localparam int FW    = FB + 1;
  localparam int HW    = rhc_pkg::HUE_INT_W + HFB;
  localparam int UW    = 6 + HFB;
  localparam int TW    = FB + 3;
  localparam int PW    = TW + 8;
  localparam int NHW   = rhc_pkg::HUE_NUM_W;
  localparam int LANES = 2;
  localparam int DW    = rhc_pkg::CHAN_W;
  localparam int NW_A  = NHW + HFB;
  localparam int NW_B  = FB + 7 + HFB;
  localparam int NW_C  = FB + 9;
  localparam int NW_AB = (NW_A > NW_B) ? NW_A : NW_B;
  localparam int NW    = (NW_AB > NW_C) ? NW_AB : NW_C;
  localparam int QW    = (HW > FW) ? HW : FW;
  localparam int SW    = 2 + rhc_pkg::SEC_W + 3 * FW + 4;
  localparam int LN    = FB + 16;
  localparam int XN    = FW + 8;
  localparam int X_DIV = rhc_pkg::HUE_SEG_DEG / 4;

  localparam logic [FW-1:0] ONE      = {1'b1, {FB{1'b0}}};
  localparam logic [UW-1:0] HUE_SEG  = UW'(rhc_pkg::HUE_SEG_DEG << HFB);
  localparam logic [HW-1:0] HUE_FULL = HW'(rhc_pkg::HUE_FULL_DEG << HFB);
  localparam logic [FB+8:0] L_RECIP  =
    (FB+9)'(((64'd1 << LN) + 64'(rhc_pkg::CHAN_MAX - 1)) / 64'(rhc_pkg::CHAN_MAX));
  localparam logic [FW+4:0] X_RECIP  =
    (FW+5)'(((64'd1 << XN) + 64'(X_DIV - 1)) / 64'(X_DIV));

  logic en;

  // stage 0: channel extremes, hsl clamps and hue wrap
  logic           v0_r;
  rhc_pkg::cmd_t  cmd0_r;
  rhc_pkg::chan_t r0_r, g0_r, b0_r, mx0_r, mn0_r;
  logic           red0_r, grn0_r;
  logic [FW-1:0]  sat0_r, lig0_r, k0_r;
  logic [HW-1:0]  hue0_r;

  rhc_pkg::chan_t mx_nxt, mn_nxt;
  logic [FW-1:0]  sat_nxt, lig_nxt, k_nxt;
  logic [FW:0]    two_l;
  logic [HW-1:0]  hue_nxt;

  always_comb begin
    mx_nxt = in_ch.in_red;
    mn_nxt = in_ch.in_red;
    if (in_ch.in_green > mx_nxt) mx_nxt = in_ch.in_green;
    if (in_ch.in_blue > mx_nxt)  mx_nxt = in_ch.in_blue;
    if (in_ch.in_green < mn_nxt) mn_nxt = in_ch.in_green;
    if (in_ch.in_blue < mn_nxt)  mn_nxt = in_ch.in_blue;
    sat_nxt = (in_ch.in_saturation > ONE) ? ONE : in_ch.in_saturation;
    lig_nxt = (in_ch.in_lightness > ONE) ? ONE : in_ch.in_lightness;
    two_l   = {lig_nxt, 1'b0};
    k_nxt   = (two_l >= {1'b0, ONE}) ? FW'({ONE, 1'b0} - two_l) : two_l[FW-1:0];
    hue_nxt = (in_ch.in_hue >= HUE_FULL) ? HW'(in_ch.in_hue - HUE_FULL) : in_ch.in_hue;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v0_r <= 1'b0;
    end else if (en) begin
      v0_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      cmd0_r <= in_ch.command;
      r0_r   <= in_ch.in_red;
      g0_r   <= in_ch.in_green;
      b0_r   <= in_ch.in_blue;
      mx0_r  <= mx_nxt;
      mn0_r  <= mn_nxt;
      red0_r <= (mx_nxt == in_ch.in_red);
      grn0_r <= (mx_nxt != in_ch.in_red) && (mx_nxt == in_ch.in_green);
      sat0_r <= sat_nxt;
      lig0_r <= lig_nxt;
      k0_r   <= k_nxt;
      hue0_r <= hue_nxt;
    end
  end

  // stage 1: division operands for rgb to hsl, chroma and sector for hsl to rgb
  logic             v1_r;
  rhc_pkg::cmd_t    cmd1_r;
  logic             grey1_r;
  logic [NW-1:0]    num_a1_r, num_b1_r, num_c1_r;
  rhc_pkg::chan_t   den_a1_r, den_b1_r;
  logic [FW-1:0]    c1_r, lig1_r;
  logic [UW-1:0]    f1_r;
  rhc_pkg::sector_t sec1_r;

  rhc_pkg::chan_t          d_nxt, gb, bg, den_s_nxt;
  logic [8:0]              s_nxt;
  logic [NHW-1:0]          n_hue;
  logic [2*FW-1:0]         kc_prod;
  logic [rhc_pkg::SEC_W-1:0] sec_idx;
  logic [HW-1:0]           seg_base;
  logic [UW-1:0]           rem_h;

  always_comb begin
    d_nxt = mx0_r - mn0_r;
    s_nxt = {1'b0, mx0_r} + {1'b0, mn0_r};
    gb    = g0_r - b0_r;
    bg    = b0_r - g0_r;
    if (red0_r) begin
      if (g0_r >= b0_r) begin
        n_hue = NHW'(rhc_pkg::HUE_SEG_DEG) * NHW'(gb);
      end else begin
        n_hue = NHW'(rhc_pkg::HUE_FULL_DEG) * NHW'(d_nxt)
              - NHW'(rhc_pkg::HUE_SEG_DEG) * NHW'(bg);
      end
    end else if (grn0_r) begin
      n_hue = NHW'(2 * rhc_pkg::HUE_SEG_DEG) * NHW'(d_nxt)
            + NHW'(rhc_pkg::HUE_SEG_DEG) * NHW'(b0_r)
            - NHW'(rhc_pkg::HUE_SEG_DEG) * NHW'(r0_r);
    end else begin
      n_hue = NHW'(4 * rhc_pkg::HUE_SEG_DEG) * NHW'(d_nxt)
            + NHW'(rhc_pkg::HUE_SEG_DEG) * NHW'(r0_r)
            - NHW'(rhc_pkg::HUE_SEG_DEG) * NHW'(g0_r);
    end
    den_s_nxt = (s_nxt <= 9'(rhc_pkg::CHAN_MAX)) ? s_nxt[7:0]
              : 8'(9'(rhc_pkg::CHAN_SUM_MAX) - s_nxt);

    kc_prod  = (2*FW)'(k0_r) * (2*FW)'(sat0_r);
    sec_idx  = '0;
    seg_base = '0;
    for (int i = 1; i < 6; i++) begin
      if (hue0_r >= HW'((i * rhc_pkg::HUE_SEG_DEG) << HFB)) begin
        sec_idx  = rhc_pkg::SEC_W'(i);
        seg_base = HW'((i * rhc_pkg::HUE_SEG_DEG) << HFB);
      end
    end
    rem_h = UW'(hue0_r - seg_base);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else if (en) begin
      v1_r <= v0_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      cmd1_r   <= cmd0_r;
      grey1_r  <= (d_nxt == '0);
      num_a1_r <= NW'(n_hue) << HFB;
      den_a1_r <= d_nxt;
      num_b1_r <= NW'(d_nxt) << FB;
      den_b1_r <= den_s_nxt;
      num_c1_r <= NW'(s_nxt) << FB;
      c1_r     <= FW'(kc_prod >> FB);
      lig1_r   <= lig0_r;
      f1_r     <= sec_idx[0] ? UW'(HUE_SEG - rem_h) : rem_h;
      sec1_r   <= rhc_pkg::sector_t'(sec_idx);
    end
  end

  // stage 2: divider inputs, chroma times sector fraction, lightness by reciprocal
  logic          v2_r;
  logic [NW-1:0] num2_r [LANES];
  logic [DW-1:0] den2_r [LANES];
  logic [SW-1:0] side2_r;

  logic [FW+UW-1:0] cf_prod;
  logic [FW+3:0]    xw_nxt;
  logic [FB+7:0]    l_num;
  logic [2*FB+16:0] l_prod;
  logic [FW-1:0]    l_quo, lig2_nxt;

  assign cf_prod  = (FW+UW)'(c1_r) * (FW+UW)'(f1_r);
  assign xw_nxt   = (FW+4)'(cf_prod >> (HFB + 2));
  assign l_num    = (FB+8)'(num_c1_r >> 1);
  assign l_prod   = (2*FB+17)'(l_num) * (2*FB+17)'(L_RECIP);
  assign l_quo    = FW'(l_prod >> LN);
  assign lig2_nxt = (cmd1_r == rhc_pkg::CMD_TO_RGB) ? lig1_r : l_quo;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r <= 1'b0;
    end else if (en) begin
      v2_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      num2_r[0] <= num_a1_r;
      den2_r[0] <= DW'(den_a1_r);
      num2_r[1] <= num_b1_r;
      den2_r[1] <= DW'(den_b1_r);
      side2_r   <= {cmd1_r, grey1_r, sec1_r, c1_r, lig2_nxt, xw_nxt};
    end
  end

  // division: hue, saturation
  logic          vd;
  logic [QW-1:0] quo [LANES];
  logic [SW-1:0] side_d;

  rhc_divider #(
    .LANES (LANES),
    .NW    (NW),
    .DW    (DW),
    .QW    (QW),
    .SW    (SW)
  ) u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (v2_r),
    .num       (num2_r),
    .den       (den2_r),
    .side_in   (side2_r),
    .out_valid (vd),
    .quo       (quo),
    .side_out  (side_d)
  );

  // post stage 1: x by reciprocal and channel sums for hsl to rgb, hsl fields for rgb to hsl
  logic                      cmd_bit;
  logic [rhc_pkg::SEC_W-1:0] sec_bits;
  rhc_pkg::cmd_t             cmd_d;
  logic                      grey_d;
  rhc_pkg::sector_t          sec_d;
  logic [FW-1:0]             c_d, lig_d, x_d;
  logic [FW+3:0]             xw_d;
  logic [2*FW+8:0]           x_prod;
  logic [FW:0]               base_d;
  logic [FW-1:0]             rv, gv, bv;

  assign {cmd_bit, grey_d, sec_bits, c_d, lig_d, xw_d} = side_d;
  assign cmd_d  = rhc_pkg::cmd_t'(cmd_bit);
  assign sec_d  = rhc_pkg::sector_t'(sec_bits);
  assign x_prod = (2*FW+9)'(xw_d) * (2*FW+9)'(X_RECIP);
  assign x_d    = FW'(x_prod >> XN);
  assign base_d = {lig_d, 1'b0} - {1'b0, c_d};

  always_comb begin
    rv = '0;
    gv = '0;
    bv = '0;
    unique case (sec_d)
      rhc_pkg::SEC_RED_YEL: begin rv = c_d; gv = x_d; end
      rhc_pkg::SEC_YEL_GRN: begin rv = x_d; gv = c_d; end
      rhc_pkg::SEC_GRN_CYN: begin gv = c_d; bv = x_d; end
      rhc_pkg::SEC_CYN_BLU: begin gv = x_d; bv = c_d; end
      rhc_pkg::SEC_BLU_MAG: begin rv = x_d; bv = c_d; end
      default:              begin rv = c_d; bv = x_d; end
    endcase
  end

  logic          vp_r;
  rhc_pkg::cmd_t cmdp_r;
  logic [TW-1:0] tr_r, tg_r, tb_r;
  logic [HW-1:0] huep_r;
  logic [FW-1:0] satp_r, ligp_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vp_r <= 1'b0;
    end else if (en) begin
      vp_r <= vd;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      cmdp_r <= cmd_d;
      tr_r   <= TW'({rv, 1'b0}) + TW'(base_d);
      tg_r   <= TW'({gv, 1'b0}) + TW'(base_d);
      tb_r   <= TW'({bv, 1'b0}) + TW'(base_d);
      huep_r <= grey_d ? '0 : HW'(quo[0]);
      satp_r <= grey_d ? '0 : FW'(quo[1]);
      ligp_r <= lig_d;
    end
  end

  // post stage 2: scale to bytes, saturate, output register
  function automatic rhc_pkg::chan_t to_byte(input logic [TW-1:0] t);
    logic [PW-1:0]    prod;
    logic [PW-FW-1:0] sh;
    prod = (PW'(t) << 8) - PW'(t);
    sh   = (PW-FW)'(prod >> FW);
    return (sh > (PW-FW)'(rhc_pkg::CHAN_MAX)) ? rhc_pkg::chan_t'(rhc_pkg::CHAN_MAX)
                                              : sh[7:0];
  endfunction

  logic           vo_r;
  rhc_pkg::chan_t red_r, green_r, blue_r;
  logic [HW-1:0]  hue_r;
  logic [FW-1:0]  sat_r, lig_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vo_r <= 1'b0;
    end else if (en) begin
      vo_r <= vp_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      if (cmdp_r == rhc_pkg::CMD_TO_RGB) begin
        red_r   <= to_byte(tr_r);
        green_r <= to_byte(tg_r);
        blue_r  <= to_byte(tb_r);
        hue_r   <= '0;
        sat_r   <= '0;
        lig_r   <= '0;
      end else begin
        red_r   <= '0;
        green_r <= '0;
        blue_r  <= '0;
        hue_r   <= huep_r;
        sat_r   <= satp_r;
        lig_r   <= ligp_r;
      end
    end
  end

  assign en                    = !vo_r || out_ch.ready;
  assign in_ch.ready           = en;
  assign out_ch.valid          = vo_r;
  assign out_ch.out_red        = red_r;
  assign out_ch.out_green      = green_r;
  assign out_ch.out_blue       = blue_r;
  assign out_ch.out_hue        = hue_r;
  assign out_ch.out_saturation = sat_r;
  assign out_ch.out_lightness  = lig_r;

endmodule
